/* rtl/dcl_pkg.sv */
// ============================================================================
// dcl_pkg
// Shared types, sizes and the sigmoid table for the digit classifier.
// ============================================================================
package dcl_pkg;

    localparam int N_INPUTS    = 784;
    localparam int N_HIDDEN    = 16;
    localparam int N_CLASSES   = 10;
    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 12;
    localparam int ACT_W       = 12;
    localparam int L2_BASE     = N_HIDDEN * (N_INPUTS + 1);
    localparam int L3_BASE     = L2_BASE + N_HIDDEN * (N_HIDDEN + 1);
    localparam int PARAM_DEPTH = L3_BASE + N_CLASSES * (N_HIDDEN + 1);
    localparam int PADDR_W     = $clog2(PARAM_DEPTH);
    localparam int IADDR_W     = $clog2(N_INPUTS);
    localparam int J_W         = $clog2(N_INPUTS + 1);
    localparam int NRN_W       = $clog2(N_HIDDEN);
    localparam int HSEL_W      = $clog2(N_HIDDEN);
    localparam int CLS_W       = 4;
    localparam int CNT_W       = 20;
    localparam int PROD_W      = 2 * DATA_W + 1;
    // 784 products of 2^30 plus a shifted bias stay well inside 44 bits
    localparam int ACC_W       = 44;
    localparam int IDX_SHIFT   = 2 * FRAC_BITS - 4;
    localparam int LAYER_W     = 2;

    localparam logic [J_W-1:0]     L1_FAN_IN  = J_W'(N_INPUTS);
    localparam logic [J_W-1:0]     L23_FAN_IN = J_W'(N_HIDDEN);
    localparam logic [NRN_W:0]     HID_LAST   = (NRN_W+1)'(N_HIDDEN - 1);
    localparam logic [NRN_W:0]     CLS_LAST_N = (NRN_W+1)'(N_CLASSES - 1);
    localparam logic [CLS_W-1:0]   CLS_LAST   = CLS_W'(N_CLASSES - 1);
    localparam logic [CNT_W-1:0]   COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic signed [ACC_W-1:0] IDX_LIM = ACC_W'(64'd128 << IDX_SHIFT);

    localparam logic [LAYER_W-1:0] LAYER_1    = 2'd0;
    localparam logic [LAYER_W-1:0] LAYER_2    = 2'd1;
    localparam logic [LAYER_W-1:0] LAYER_3    = 2'd2;
    localparam logic [LAYER_W-1:0] LAYER_DONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_ARGMAX,
        ST_DONE
    } t_state;

    // one MAC step issued by the sequencer
    typedef struct packed {
        logic               valid;
        logic               bias;
        logic [LAYER_W-1:0] layer;
        logic [NRN_W-1:0]   nrn;
        logic [HSEL_W-1:0]  sel;
    } t_issue;

    typedef logic [ACT_W-1:0] t_sig_rom [256];

    // elaboration-time table build; restoring division, no divider in hardware
    function automatic t_sig_rom build_sig_rom();
        t_sig_rom    rom;
        logic [63:0] e [129];
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        e[0] = 64'd1 << 30;
        for (int m = 0; m < 128; m++) begin
            e[m+1] = (e[m] * 64'd1008687095 + (64'd1 << 29)) >> 30;
        end
        for (int k = 0; k < 256; k++) begin
            if (k >= 128) begin
                den = (64'd1 << 30) + e[k-128];
                num = 64'd1 << 42;
            end else begin
                den = (64'd1 << 30) + e[128-k];
                num = e[128-k] << 12;
            end
            num = num + (den >> 1);
            q = '0;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                r = {r[62:0], num[b]};
                if (r >= den) begin
                    r = r - den;
                    q[b] = 1'b1;
                end
            end
            rom[k] = (q > 64'd4095) ? 12'hfff : q[ACT_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

endpackage

/* rtl/dcl_ram.sv */
// ============================================================================
// dcl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module dcl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* rtl/dcl_engine.sv */
// ============================================================================
// dcl_engine
// MAC pipeline: operand select, multiply, accumulate, sigmoid and the
// activation registers of all three layers.
// ============================================================================
module dcl_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dcl_pkg::t_issue             i_issue,
    input  logic signed [dcl_pkg::DATA_W-1:0] i_weight,
    input  logic signed [dcl_pkg::DATA_W-1:0] i_pixel,
    input  logic [dcl_pkg::CLS_W-1:0]   i_out_sel,
    output logic                        o_pipe_empty,
    output logic [dcl_pkg::ACT_W-1:0]   o_out_act
);

    logic [dcl_pkg::ACT_W-1:0] r_h1  [dcl_pkg::N_HIDDEN];
    logic [dcl_pkg::ACT_W-1:0] r_h2  [dcl_pkg::N_HIDDEN];
    logic [dcl_pkg::ACT_W-1:0] r_out [dcl_pkg::N_CLASSES];

    dcl_pkg::t_issue                    r_b;
    logic [dcl_pkg::ACT_W-1:0]          r_b_act;
    logic                               r_c_valid;
    logic                               r_c_bias;
    logic [dcl_pkg::LAYER_W-1:0]        r_c_layer;
    logic [dcl_pkg::NRN_W-1:0]          r_c_nrn;
    logic signed [dcl_pkg::ACC_W-1:0]   r_c_prod;
    logic signed [dcl_pkg::ACC_W-1:0]   r_acc;
    logic                               r_d_valid;
    logic [dcl_pkg::LAYER_W-1:0]        r_d_layer;
    logic [dcl_pkg::NRN_W-1:0]          r_d_nrn;
    logic signed [dcl_pkg::ACC_W-1:0]   r_d_sum;

    logic signed [dcl_pkg::DATA_W:0]    x_op;
    logic signed [dcl_pkg::PROD_W-1:0]  prod;
    logic signed [dcl_pkg::ACC_W-1:0]   acc_sum;
    logic signed [dcl_pkg::ACC_W-1:0]   idx_base;
    logic [7:0]                         sig_idx;
    logic [dcl_pkg::ACT_W-1:0]          act_val;

    function automatic logic signed [dcl_pkg::ACC_W-1:0] ACC_W_SHIFT(
        input logic signed [dcl_pkg::DATA_W-1:0] w
    );
        return dcl_pkg::ACC_W'(w) <<< dcl_pkg::FRAC_BITS;
    endfunction

    // stage A: fetch activation operand alongside the RAM reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else begin
            r_b.valid <= i_issue.valid;
        end
        r_b.bias  <= i_issue.bias;
        r_b.layer <= i_issue.layer;
        r_b.nrn   <= i_issue.nrn;
        r_b.sel   <= i_issue.sel;
        r_b_act   <= (i_issue.layer == dcl_pkg::LAYER_2) ? r_h1[i_issue.sel]
                                                         : r_h2[i_issue.sel];
    end

    // stage B: multiply
    always_comb begin
        x_op = (r_b.layer == dcl_pkg::LAYER_1) ? {i_pixel[dcl_pkg::DATA_W-1], i_pixel}
                                               : {5'b0, r_b_act};
        prod = x_op * i_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b.valid;
        end
        r_c_bias  <= r_b.bias;
        r_c_layer <= r_b.layer;
        r_c_nrn   <= r_b.nrn;
        if (r_b.bias) begin
            r_c_prod <= ACC_W_SHIFT(i_weight);
        end else begin
            r_c_prod <= dcl_pkg::ACC_W'(prod);
        end
    end

    // stage C: accumulate, bias closes the neuron
    assign acc_sum = r_acc + r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid && r_c_bias;
            if (r_c_valid) begin
                r_acc <= r_c_bias ? '0 : acc_sum;
            end
        end
        r_d_sum   <= acc_sum;
        r_d_layer <= r_c_layer;
        r_d_nrn   <= r_c_nrn;
    end

    // stage D: sigmoid lookup and write-back
    always_comb begin
        idx_base = r_d_sum + dcl_pkg::IDX_LIM;
        if (r_d_sum >= dcl_pkg::IDX_LIM) begin
            sig_idx = 8'd255;
        end else if (r_d_sum < -dcl_pkg::IDX_LIM) begin
            sig_idx = 8'd0;
        end else begin
            sig_idx = idx_base[dcl_pkg::IDX_SHIFT +: 8];
        end
        act_val = dcl_pkg::SIG_ROM[sig_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_d_valid) begin
            unique case (r_d_layer)
                dcl_pkg::LAYER_1: r_h1[r_d_nrn] <= act_val;
                dcl_pkg::LAYER_2: r_h2[r_d_nrn] <= act_val;
                default:          r_out[r_d_nrn[dcl_pkg::CLS_W-1:0]] <= act_val;
            endcase
        end
    end

    assign o_pipe_empty = !r_b.valid && !r_c_valid && !r_d_valid;
    assign o_out_act    = r_out[i_out_sel];

endmodule

/* rtl/dcl_seq.sv */
// ============================================================================
// dcl_seq
// Pass sequencer: walks the parameter store, drains between layers, runs the
// argmax and produces the result.
// ============================================================================
module dcl_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [3:0]                    i_label,
    input  logic                          i_pipe_empty,
    input  logic [dcl_pkg::ACT_W-1:0]     i_out_act,
    output logic                          o_busy,
    output dcl_pkg::t_issue               o_issue,
    output logic [dcl_pkg::PADDR_W-1:0]   o_paddr,
    output logic [dcl_pkg::IADDR_W-1:0]   o_iaddr,
    output logic [dcl_pkg::CLS_W-1:0]     o_out_sel,
    output logic                          o_result_valid,
    output logic [dcl_pkg::CLS_W-1:0]     o_class,
    output logic                          o_correct,
    output logic [dcl_pkg::CNT_W-1:0]     o_count
);

    dcl_pkg::t_state                r_state, n_state;
    logic [dcl_pkg::J_W-1:0]        r_j, n_j;
    logic [dcl_pkg::NRN_W:0]        r_nrn, n_nrn;
    logic [dcl_pkg::LAYER_W-1:0]    r_layer, n_layer;
    logic [dcl_pkg::PADDR_W-1:0]    r_paddr, n_paddr;
    logic [dcl_pkg::CLS_W-1:0]      r_k, n_k;
    logic [dcl_pkg::CLS_W-1:0]      r_best, n_best;
    logic [dcl_pkg::ACT_W-1:0]      r_best_val, n_best_val;
    logic [3:0]                     r_label, n_label;
    logic [dcl_pkg::CNT_W-1:0]      r_count, n_count;
    logic                           r_res_valid, n_res_valid;
    logic [dcl_pkg::CLS_W-1:0]      r_class, n_class;
    logic                           r_correct, n_correct;

    logic [dcl_pkg::J_W-1:0]        fan_in;
    logic [dcl_pkg::NRN_W:0]        nrn_last;
    logic                           hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcl_pkg::ST_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_j        <= n_j;
        r_nrn      <= n_nrn;
        r_layer    <= n_layer;
        r_paddr    <= n_paddr;
        r_k        <= n_k;
        r_best     <= n_best;
        r_best_val <= n_best_val;
        r_label    <= n_label;
        r_class    <= n_class;
        r_correct  <= n_correct;
    end

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_nrn       = r_nrn;
        n_layer     = r_layer;
        n_paddr     = r_paddr;
        n_k         = r_k;
        n_best      = r_best;
        n_best_val  = r_best_val;
        n_label     = r_label;
        n_count     = r_count;
        n_res_valid = 1'b0;
        n_class     = r_class;
        n_correct   = r_correct;

        fan_in   = (r_layer == dcl_pkg::LAYER_1) ? dcl_pkg::L1_FAN_IN : dcl_pkg::L23_FAN_IN;
        nrn_last = (r_layer == dcl_pkg::LAYER_3) ? dcl_pkg::CLS_LAST_N : dcl_pkg::HID_LAST;
        hit      = (r_best == r_label);

        o_issue.valid = 1'b0;
        o_issue.bias  = (r_j == fan_in);
        o_issue.layer = r_layer;
        o_issue.nrn   = r_nrn[dcl_pkg::NRN_W-1:0];
        o_issue.sel   = r_j[dcl_pkg::HSEL_W-1:0];

        unique case (r_state)
            dcl_pkg::ST_IDLE: begin
                if (i_go) begin
                    n_label = i_label;
                    n_j     = '0;
                    n_nrn   = '0;
                    n_layer = dcl_pkg::LAYER_1;
                    n_paddr = '0;
                    n_state = dcl_pkg::ST_RUN;
                end
            end
            dcl_pkg::ST_RUN: begin
                o_issue.valid = 1'b1;
                n_paddr = r_paddr + 1'b1;
                if (r_j == fan_in) begin
                    n_j = '0;
                    if (r_nrn == nrn_last) begin
                        n_nrn   = '0;
                        n_layer = r_layer + 1'b1;
                        n_state = dcl_pkg::ST_WAIT;
                    end else begin
                        n_nrn = r_nrn + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            dcl_pkg::ST_WAIT: begin
                // next layer reads activations only after the pipe is empty
                if (i_pipe_empty) begin
                    if (r_layer == dcl_pkg::LAYER_DONE) begin
                        n_k     = '0;
                        n_state = dcl_pkg::ST_ARGMAX;
                    end else begin
                        n_state = dcl_pkg::ST_RUN;
                    end
                end
            end
            dcl_pkg::ST_ARGMAX: begin
                if (r_k == '0 || i_out_act > r_best_val) begin
                    n_best     = r_k;
                    n_best_val = i_out_act;
                end
                if (r_k == dcl_pkg::CLS_LAST) begin
                    n_state = dcl_pkg::ST_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            dcl_pkg::ST_DONE: begin
                if (hit && r_count != dcl_pkg::COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                n_class     = r_best;
                n_correct   = hit;
                n_res_valid = 1'b1;
                n_state     = dcl_pkg::ST_IDLE;
            end
            default: n_state = dcl_pkg::ST_IDLE;
        endcase
    end

    assign o_busy         = (r_state != dcl_pkg::ST_IDLE);
    assign o_paddr        = r_paddr;
    assign o_iaddr        = r_j[dcl_pkg::IADDR_W-1:0];
    assign o_out_sel      = r_k;
    assign o_result_valid = r_res_valid;
    assign o_class        = r_class;
    assign o_correct      = r_correct;
    assign o_count        = r_count;

endmodule

/* rtl/mlp_digit_classifier_unit.sv */
// ============================================================================
// mlp_digit_classifier_unit
// 784-16-16-10 sigmoid MLP inference with argmax, one shared MAC.
// ============================================================================
// Usage:
//   Commands transfer on a rising edge with start high and busy low.
//   i_mode 0 writes i_value into the parameter store at i_addr.
//   i_mode 1 writes a pixel at i_addr; with i_last_pixel set it also starts
//   a forward pass and busy rises on the next cycle. Out-of-range addresses
//   are dropped, last-pixel flag included.
//   A pass streams all 13002 parameter words through the single MAC, one
//   word per cycle out of the parameter RAM read port, with a short pipe
//   drain after each layer and an argmax that steps through the ten class
//   outputs before the result strobe.
//   The result (class, correct flag, saturating correct count) is shown for
//   one cycle with o_result_valid; there is no backpressure, the receiver
//   must take it. busy is already low in that cycle.
//   Reset clears the sequencer, pipe and count; stores hold garbage until
//   written.
// ============================================================================
module mlp_digit_classifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [13:0]                       i_addr,
    input  logic signed [dcl_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last_pixel,
    input  logic [3:0]                        i_label,
    output logic                              o_result_valid,
    output logic [dcl_pkg::CLS_W-1:0]         o_predicted_class,
    output logic                              o_is_correct,
    output logic [dcl_pkg::CNT_W-1:0]         o_correct_count
);

    logic                               accept;
    logic                               p_we;
    logic                               i_we;
    logic                               go;
    logic [dcl_pkg::DATA_W-1:0]         weight;
    logic [dcl_pkg::DATA_W-1:0]         pixel;
    dcl_pkg::t_issue                    issue;
    logic [dcl_pkg::PADDR_W-1:0]        paddr;
    logic [dcl_pkg::IADDR_W-1:0]        iaddr;
    logic [dcl_pkg::CLS_W-1:0]          out_sel;
    logic [dcl_pkg::ACT_W-1:0]          out_act;
    logic                               pipe_empty;

    assign accept = start && !busy;
    assign p_we   = accept && !i_mode && (i_addr < 14'(dcl_pkg::PARAM_DEPTH));
    assign i_we   = accept && i_mode && (i_addr < 14'(dcl_pkg::N_INPUTS));
    assign go     = i_we && i_last_pixel;

    dcl_ram #(
        .DEPTH(dcl_pkg::PARAM_DEPTH),
        .WIDTH(dcl_pkg::DATA_W)
    ) u_param_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(i_addr[dcl_pkg::PADDR_W-1:0]),
        .i_wdata(i_value),
        .i_raddr(paddr),
        .o_rdata(weight)
    );

    dcl_ram #(
        .DEPTH(dcl_pkg::N_INPUTS),
        .WIDTH(dcl_pkg::DATA_W)
    ) u_image_ram (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_addr[dcl_pkg::IADDR_W-1:0]),
        .i_wdata(i_value),
        .i_raddr(iaddr),
        .o_rdata(pixel)
    );

    dcl_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_label       (i_label),
        .i_pipe_empty  (pipe_empty),
        .i_out_act     (out_act),
        .o_busy        (busy),
        .o_issue       (issue),
        .o_paddr       (paddr),
        .o_iaddr       (iaddr),
        .o_out_sel     (out_sel),
        .o_result_valid(o_result_valid),
        .o_class       (o_predicted_class),
        .o_correct     (o_is_correct),
        .o_count       (o_correct_count)
    );

    dcl_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_weight    (weight),
        .i_pixel     (pixel),
        .i_out_sel   (out_sel),
        .o_pipe_empty(pipe_empty),
        .o_out_act   (out_act)
    );

endmodule

/* rtl/dcl_checker.sv */
// ============================================================================
// dcl_checker
// Port-level checks of the classifier, bound to the top level.
// ============================================================================
module dcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_mode,
    input logic [13:0] i_addr,
    input logic        i_last_pixel,
    input logic        o_result_valid,
    input logic [3:0]  o_predicted_class
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_valid)
        else $error("busy or result after reset");

    a_pass_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode && i_last_pixel && (i_addr < 14'd784) |=> busy)
        else $error("last pixel did not start a pass");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy && $past(busy))
        else $error("result outside end of pass");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_predicted_class < 4'd10)
        else $error("class out of range");

endmodule

bind mlp_digit_classifier_unit dcl_checker u_dcl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_mode           (i_mode),
    .i_addr           (i_addr),
    .i_last_pixel     (i_last_pixel),
    .o_result_valid   (o_result_valid),
    .o_predicted_class(o_predicted_class)
);

/* bench/mlp_digit_classifier_unit_test.sv */
// ----------------------------------------------------------------------------
// mlp_digit_classifier_unit_test
// Loads the full parameter set, then streams pixel updates that trigger
// forward passes. A scoreboard recomputes each pass in fixed point and
// checks class, hit flag and running count of every result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class classifier_scoreboard;
    typedef struct {
        logic [dcl_pkg::CLS_W-1:0] cls;
        logic                      hit;
        logic [dcl_pkg::CNT_W-1:0] count;
    } t_outcome;

    int                        weights [dcl_pkg::PARAM_DEPTH];
    int                        pixels  [dcl_pkg::N_INPUTS];
    logic [11:0]               sig_lut [256];
    logic [dcl_pkg::CNT_W-1:0] hits;
    t_outcome                  pending [$];
    int                        errors;

    function new();
        longint unsigned e [129];
        longint unsigned num, den;
        e[0] = 64'd1 << 30;
        for (int m = 0; m < 128; m++)
            e[m+1] = (e[m] * 64'd1008687095 + (64'd1 << 29)) >> 30;
        for (int k = 0; k < 256; k++) begin
            if (k >= 128) begin
                den = (64'd1 << 30) + e[k-128];
                num = 64'd1 << 42;
            end else begin
                den = (64'd1 << 30) + e[128-k];
                num = e[128-k] << 12;
            end
            num = (num + den / 2) / den;
            sig_lut[k] = (num > 4095) ? 12'hfff : num[11:0];
        end
        hits   = '0;
        errors = 0;
    endfunction

    // sums stay far below 2^63, so no saturation is needed here
    function logic [11:0] squash(longint acc, int bias);
        longint lim;
        longint idx;
        lim = longint'(128) << dcl_pkg::IDX_SHIFT;
        acc = acc + longint'(bias) * 4096;
        if (acc >= lim) idx = 255;
        else if (acc < -lim) idx = 0;
        else idx = (acc + lim) >>> dcl_pkg::IDX_SHIFT;
        return sig_lut[idx];
    endfunction

    function int classify();
        logic [11:0] h1 [dcl_pkg::N_HIDDEN];
        logic [11:0] h2 [dcl_pkg::N_HIDDEN];
        logic [11:0] outs [dcl_pkg::N_CLASSES];
        longint      acc;
        int          row, best;
        for (int i = 0; i < dcl_pkg::N_HIDDEN; i++) begin
            row = i * (dcl_pkg::N_INPUTS + 1);
            acc = 0;
            for (int j = 0; j < dcl_pkg::N_INPUTS; j++)
                acc += longint'(pixels[j]) * weights[row + j];
            h1[i] = squash(acc, weights[row + dcl_pkg::N_INPUTS]);
        end
        for (int i = 0; i < dcl_pkg::N_HIDDEN; i++) begin
            row = dcl_pkg::L2_BASE + i * (dcl_pkg::N_HIDDEN + 1);
            acc = 0;
            for (int j = 0; j < dcl_pkg::N_HIDDEN; j++)
                acc += longint'(h1[j]) * weights[row + j];
            h2[i] = squash(acc, weights[row + dcl_pkg::N_HIDDEN]);
        end
        for (int i = 0; i < dcl_pkg::N_CLASSES; i++) begin
            row = dcl_pkg::L3_BASE + i * (dcl_pkg::N_HIDDEN + 1);
            acc = 0;
            for (int j = 0; j < dcl_pkg::N_HIDDEN; j++)
                acc += longint'(h2[j]) * weights[row + j];
            outs[i] = squash(acc, weights[row + dcl_pkg::N_HIDDEN]);
        end
        best = 0;
        for (int i = 1; i < dcl_pkg::N_CLASSES; i++)
            if (outs[i] > outs[best]) best = i;
        return best;
    endfunction

    function void note_transfer(logic mode, logic [13:0] addr, logic signed [15:0] value,
                                logic last, logic [3:0] label);
        t_outcome o;
        if (!mode) begin
            if (addr < dcl_pkg::PARAM_DEPTH) weights[addr] = value;
            return;
        end
        if (addr >= dcl_pkg::N_INPUTS) return;
        pixels[addr] = value;
        if (!last) return;
        o.cls = classify();
        o.hit = (o.cls == label);
        if (o.hit && hits != dcl_pkg::COUNT_MAX) hits++;
        o.count = hits;
        pending.push_back(o);
    endfunction

    function void check_result(logic [dcl_pkg::CLS_W-1:0] cls, logic hit,
                               logic [dcl_pkg::CNT_W-1:0] count);
        t_outcome o;
        if (pending.size() == 0) begin
            $error("unexpected result strobe: class %0d", cls);
            errors++;
            return;
        end
        o = pending.pop_front();
        if (cls !== o.cls) begin
            $error("predicted_class expected %0d got %0d", o.cls, cls);
            errors++;
        end
        if (hit !== o.hit) begin
            $error("is_correct expected %0d got %0d", o.hit, hit);
            errors++;
        end
        if (count !== o.count) begin
            $error("correct_count expected %0d got %0d", o.count, count);
            errors++;
        end
    endfunction
endclass

module mlp_digit_classifier_unit_test;
    localparam int CYCLE_LIMIT = 3000000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_mode = 1'b0;
    logic [13:0]               i_addr = '0;
    logic signed [15:0]        i_value = '0;
    logic                      i_last_pixel = 1'b0;
    logic [3:0]                i_label = '0;
    logic                      o_result_valid;
    logic [dcl_pkg::CLS_W-1:0] o_predicted_class;
    logic                      o_is_correct;
    logic [dcl_pkg::CNT_W-1:0] o_correct_count;

    classifier_scoreboard sb = new();
    int idle_pct = 0;
    int cycles = 0;

    mlp_digit_classifier_unit uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("mlp_digit_classifier_unit verification failed");
            $finish;
        end
        if (i_rst_n && o_result_valid)
            sb.check_result(o_predicted_class, o_is_correct, o_correct_count);
    end

    task automatic send(logic mode, logic [13:0] addr, logic [15:0] value,
                        logic last, logic [3:0] label);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_mode       = mode;
        i_addr       = addr;
        i_value      = value;
        i_last_pixel = last;
        i_label      = label;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(mode, addr, value, last, label);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // mostly small weights so activations land inside the table, not on its rails
    function automatic logic [15:0] rand_weight();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(1023) - 512);
    endfunction

    initial begin
        int rounds;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // edge values at the store bounds, ignored writes
        send(1'b0, 14'd0, 16'h8000, 1'b1, 4'd0);
        send(1'b0, 14'(dcl_pkg::PARAM_DEPTH - 1), 16'h7fff, 1'b0, 4'd0);
        send(1'b0, 14'(dcl_pkg::PARAM_DEPTH), 16'h1234, 1'b0, 4'd0);
        send(1'b0, 14'h3fff, 16'hffff, 1'b1, 4'd15);
        send(1'b1, 14'(dcl_pkg::N_INPUTS), 16'h7fff, 1'b1, 4'd3);
        send(1'b1, 14'h3fff, 16'h8000, 1'b1, 4'd3);

        // every store word must be written before a pass reads it
        for (int a = 0; a < dcl_pkg::PARAM_DEPTH; a++)
            send(1'b0, 14'(a), rand_weight(), 1'b0, 4'd0);
        for (int p = 0; p < dcl_pkg::N_INPUTS; p++)
            send(1'b1, 14'(p), 16'($urandom_range(4095)), 1'b0, 4'd0);

        send(1'b1, 14'd0, 16'h7fff, 1'b1, 4'($urandom_range(9)));
        send(1'b1, 14'(dcl_pkg::N_INPUTS - 1), 16'h8000, 1'b1, 4'd12);
        send(1'b1, 14'd5, 16'h0000, 1'b1, 4'd15);
        send(1'b1, 14'd6, 16'hffff, 1'b1, 4'd10);

        rounds = 40;
        for (int r = 0; r < rounds; r++) begin
            case ((r / 5) % 3)
                0: idle_pct = 0;
                1: idle_pct = 86;
                default: idle_pct = 11;
            endcase
            if (r == 20) drain();
            for (int n = $urandom_range(30, 18); n > 0; n--) begin
                case ($urandom_range(9))
                    0: send(1'b0, 14'($urandom_range(dcl_pkg::PARAM_DEPTH - 1)),
                            rand_weight(), 1'($urandom), 4'($urandom));
                    1: send(1'b1, 14'($urandom_range(16383, dcl_pkg::N_INPUTS)),
                            16'($urandom), 1'($urandom), 4'($urandom));
                    2: send(1'b0, 14'($urandom_range(16383, dcl_pkg::PARAM_DEPTH)),
                            16'($urandom), 1'($urandom), 4'($urandom));
                    3: send(1'b1, 14'($urandom_range(dcl_pkg::N_INPUTS - 1)),
                            16'($urandom), 1'b0, 4'($urandom));
                    default: send(1'b1, 14'($urandom_range(dcl_pkg::N_INPUTS - 1)),
                                  16'($urandom_range(4095)), 1'b0, 4'($urandom));
                endcase
            end
            send(1'b1, 14'($urandom_range(dcl_pkg::N_INPUTS - 1)),
                 16'($urandom_range(4095)), 1'b1,
                 ($urandom_range(4) == 0) ? 4'($urandom_range(15, 10))
                                          : 4'($urandom_range(9)));
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("mlp_digit_classifier_unit verification clean");
        else
            $display("mlp_digit_classifier_unit verification failed");
        $finish;
    end
endmodule
